// ===== rtl/bmfn_pkg.sv =====
package bmfn_pkg;

    // array geometry
    localparam int NUM_BITS    = 1024;
    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = NUM_BITS / WORD_W;
    localparam int BIT_IDX_W   = $clog2(NUM_BITS);
    localparam int WORD_OFF_W  = $clog2(WORD_W);
    localparam int WORD_ADDR_W = BIT_IDX_W - WORD_OFF_W;
    localparam int LIM_W       = BIT_IDX_W + 1;
    localparam int BYTE_CNT_W  = 8;
    localparam int NUM_BYTES   = NUM_BITS / 8;
    localparam int FUNC_W      = 3;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_TEST  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FILL  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FIND  = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [BIT_IDX_W-1:0] bit_index;
        logic                 wanted_value;
    } bmfn_in_t;

    typedef struct packed {
        logic                 bit_value;
        logic                 found;
        logic [BIT_IDX_W-1:0] found_index;
    } bmfn_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic word_clear;
        logic word_inc;
        logic wr;
        logic pend_load;
        logic out_load;
    } bmfn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              hit;
        logic              last;
    } bmfn_sts_t;

endpackage

// ===== rtl/bmfn_dpath.sv =====
module bmfn_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bmfn_pkg::BYTE_CNT_W-1:0]       cfg_wdata,
    input  bmfn_pkg::bmfn_in_t                    in_data,
    input  bmfn_pkg::bmfn_cmd_t                   cmd,
    output bmfn_pkg::bmfn_sts_t                   sts,
    output bmfn_pkg::bmfn_out_t                   out_data
);
    import bmfn_pkg::*;

    logic [BYTE_CNT_W-1:0]  bytes_reg;
    logic [BYTE_CNT_W-1:0]  sat_bytes;
    logic [LIM_W-1:0]       lim;
    bmfn_in_t               op_reg;
    logic [WORD_ADDR_W-1:0] word_reg;
    logic [WORD_ADDR_W-1:0] word_next;
    logic [WORD_W-1:0]      mem_reg [NUM_WORDS];
    logic [NUM_WORDS-1:0]   row_valid_reg;
    logic [WORD_W-1:0]      rd_data_reg;
    logic                   rd_valid_reg;
    logic [WORD_W-1:0]      word_data;
    logic [LIM_W-1:0]       word_base;
    logic [LIM_W-1:0]       next_base;
    logic [LIM_W-1:0]       lim_diff;
    logic [WORD_W-1:0]      inuse_mask;
    logic [WORD_W-1:0]      start_mask;
    logic [WORD_W-1:0]      bit_mask;
    logic [WORD_W-1:0]      wr_mask;
    logic                   wr_bit;
    logic [WORD_W-1:0]      cand;
    logic [WORD_OFF_W-1:0]  enc;
    logic                   in_range;
    bmfn_out_t              res;
    bmfn_out_t              pend_reg;
    bmfn_out_t              out_reg;

    // size register, saturated to the array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bytes_reg <= BYTE_CNT_W'(NUM_BYTES);
        else if (cfg_we)
            bytes_reg <= cfg_wdata;
    end

    assign sat_bytes = (bytes_reg > BYTE_CNT_W'(NUM_BYTES)) ? BYTE_CNT_W'(NUM_BYTES) : bytes_reg;
    assign lim       = LIM_W'({sat_bytes, 3'b000});

    // captured transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            op_reg <= in_data;
    end

    // word pointer
    always_comb
    begin
        word_next = word_reg;
        if (cmd.load)
            word_next = in_data.bit_index[BIT_IDX_W-1:WORD_OFF_W];
        else if (cmd.word_clear)
            word_next = '0;
        else if (cmd.word_inc)
            word_next = word_reg + WORD_ADDR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else
            word_reg <= word_next;
    end

    // row valid bits, cleared at reset; an invalid row reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
                row_valid_reg[word_reg] <= 1'b1;
            rd_valid_reg <= row_valid_reg[word_next];
        end
    end

    // bit-masked write; first write to a row fills the rest with zeros
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            if (row_valid_reg[word_reg])
            begin
                for (int b = 0; b < WORD_W; b++)
                begin
                    if (wr_mask[b[WORD_OFF_W-1:0]])
                        mem_reg[word_reg][b[WORD_OFF_W-1:0]] <= wr_bit;
                end
            end
            else
                mem_reg[word_reg] <= wr_mask & {WORD_W{wr_bit}};
        end
    end

    // registered read, always of the word the pointer holds next
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[word_next];
    end

    assign word_data = rd_valid_reg ? rd_data_reg : '0;

    // in-use bits of the current word
    assign word_base = LIM_W'({1'b0, word_reg, {WORD_OFF_W{1'b0}}});
    assign next_base = LIM_W'({({1'b0, word_reg} + (WORD_ADDR_W + 1)'(1)), {WORD_OFF_W{1'b0}}});
    assign lim_diff  = lim - word_base;

    always_comb
    begin
        if (lim <= word_base)
            inuse_mask = '0;
        else if (lim_diff >= LIM_W'(WORD_W))
            inuse_mask = '1;
        else
            inuse_mask = (WORD_W'(1) << lim_diff[WORD_OFF_W-1:0]) - WORD_W'(1);
    end

    // search starts at the start bit inside its own word
    assign start_mask = (word_reg == op_reg.bit_index[BIT_IDX_W-1:WORD_OFF_W]) ?
                        ({WORD_W{1'b1}} << op_reg.bit_index[WORD_OFF_W-1:0]) : '1;
    assign in_range   = ({1'b0, op_reg.bit_index} < lim);
    assign bit_mask   = in_range ? (WORD_W'(1) << op_reg.bit_index[WORD_OFF_W-1:0]) : '0;

    // write data and mask
    always_comb
    begin
        if (op_reg.func == FUNC_FILL)
        begin
            wr_mask = inuse_mask;
            wr_bit  = op_reg.wanted_value;
        end
        else
        begin
            wr_mask = bit_mask;
            wr_bit  = (op_reg.func == FUNC_SET);
        end
    end

    // candidates and lowest-set priority encoder
    assign cand = (op_reg.wanted_value ? word_data : ~word_data) & inuse_mask & start_mask;

    always_comb
    begin
        enc = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (cand[b[WORD_OFF_W-1:0]])
                enc = b[WORD_OFF_W-1:0];
        end
    end

    assign sts.func = op_reg.func;
    assign sts.hit  = |cand;
    assign sts.last = (next_base >= lim) || (word_reg == WORD_ADDR_W'(NUM_WORDS - 1));

    // result of the current transaction
    always_comb
    begin
        res.bit_value   = (op_reg.func == FUNC_TEST) && in_range &&
                          word_data[op_reg.bit_index[WORD_OFF_W-1:0]];
        res.found       = (op_reg.func == FUNC_FIND) && sts.hit;
        res.found_index = res.found ? {word_reg, enc} : '0;
    end

    // pending and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.pend_load)
            pend_reg <= res;
        if (cmd.out_load)
            out_reg <= pend_reg;
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/bmfn_ctrl.sv =====
module bmfn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  bmfn_pkg::bmfn_sts_t sts,
    output bmfn_pkg::bmfn_cmd_t cmd
);
    import bmfn_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_FILL = 5'b00100,
        ST_FIND = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (sts.func) inside
                    FUNC_SET, FUNC_CLEAR:
                    begin
                        cmd.wr        = 1'b1;
                        cmd.pend_load = 1'b1;
                        state_next    = ST_DONE;
                    end
                    FUNC_FILL:
                    begin
                        cmd.word_clear = 1'b1;
                        state_next     = ST_FILL;
                    end
                    FUNC_FIND:
                    begin
                        if (sts.hit || sts.last)
                        begin
                            cmd.pend_load = 1'b1;
                            state_next    = ST_DONE;
                        end
                        else
                        begin
                            cmd.word_inc = 1'b1;
                            state_next   = ST_FIND;
                        end
                    end
                    default:
                    begin
                        cmd.pend_load = 1'b1;
                        state_next    = ST_DONE;
                    end
                endcase
            end
            ST_FILL:
            begin
                cmd.wr = 1'b1;
                if (sts.last)
                begin
                    cmd.pend_load = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                    cmd.word_inc = 1'b1;
            end
            ST_FIND:
            begin
                if (sts.hit || sts.last)
                begin
                    cmd.pend_load = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                    cmd.word_inc = 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_EXEC)
        else $error("accepted transaction did not start");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> (state_reg == ST_EXEC || state_reg == ST_FILL))
        else $error("array write outside an operation");

    a_pend_states: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pend_load |=> state_reg == ST_DONE)
        else $error("result captured without moving to done");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free ##1 out_valid_reg)
        else $error("output register overwritten while held");

endmodule

// ===== rtl/bitmap_with_find_next.sv =====
// Bit array with test, set, clear, fill and find-next.
// Input channel in_valid / in_stall / in_data carries one operation per
// transaction (func, bit_index, wanted_value); it is accepted when in_valid
// is high and in_stall is low. Each transaction gives exactly one result
// on out_valid / out_stall / out_data (bit_value, found, found_index).
// cfg_we / cfg_wdata write bytes_in_use; write only while the block is idle.
// The array is kept as 64-bit words in an internal memory with a
// registered read port; one word is read or written per cycle.
// Test, set, clear and unused codes go from EXEC straight to DONE; fill
// writes the words in order from word 0 up to the end of the range in
// use, at least one; find scans word by word from the start word until
// a hit or the last word in use. The next transaction is accepted the
// cycle after a result enters the output register, so each one finishes
// before the next is taken, and a held result does not block the next one.
// Reset clears every bit through per-word valid flags at once and sets
// bytes_in_use to 128; no clearing pass is needed.
// When the receiver stalls, out_data holds; a finished result then waits
// in a pending register and in_stall stays high until it can move out.
module bitmap_with_find_next (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bmfn_pkg::BYTE_CNT_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bmfn_pkg::bmfn_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bmfn_pkg::bmfn_out_t                 out_data
);
    import bmfn_pkg::*;

    bmfn_cmd_t cmd;
    bmfn_sts_t sts;

    // sequencer
    bmfn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // array, search and result path
    bmfn_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule
